// ----- rtl/compacting_verdict_queue_core_assert.svh -----
// assertion macros shared by the verdict queue rtl
`ifndef COMPACTING_VERDICT_QUEUE_CORE_ASSERT_SVH
`define COMPACTING_VERDICT_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CVQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cvq_pkg.sv -----
// shared types, codes and field layout of the verdict queue
package cvq_pkg;

	// fixed field widths
	localparam int TIME_W    = 31;
	localparam int VERDICT_W = TIME_W + 1;
	localparam int POS_W     = 6;
	localparam int QIDX_W    = 4;
	localparam int LEN_CFG_W = 7;

	// default storage sizes
	localparam int NUM_QUEUES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 64;

	// input tdata layout
	localparam int QIDX_LSB   = 0;
	localparam int WV_LSB     = QIDX_LSB + QIDX_W;
	localparam int RP_LSB     = WV_LSB + VERDICT_W;
	localparam int WT_LSB     = RP_LSB + POS_W;
	localparam int IN_USED_W  = WT_LSB + TIME_W;
	localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// output tdata layout
	localparam int RV_LSB     = 0;
	localparam int NRP_LSB    = RV_LSB + VERDICT_W;
	localparam int OUT_USED_W = NRP_LSB + POS_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// cell read address selection
	localparam logic [1:0] RA_MOD   = 2'd0;
	localparam logic [1:0] RA_PREV  = 2'd1;
	localparam logic [1:0] RA_W     = 2'd2;
	localparam logic [1:0] RA_RNEXT = 2'd3;

	// result kinds
	localparam logic [1:0] OUT_ECHO  = 2'd0;
	localparam logic [1:0] OUT_FOUND = 2'd1;
	localparam logic [1:0] OUT_MISS  = 2'd2;

	typedef struct packed {
		logic       clr_wr;
		logic       load;
		logic       mod_start;
		logic       mod_sel_rpos;
		logic       w_load;
		logic       r_load;
		logic       rd;
		logic [1:0] ra_sel;
		logic       cap_prev;
		logic       scan_adv;
		logic       cell_wr;
		logic       out_load;
		logic [1:0] out_kind;
	} cvq_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic q_ok;
		logic op_read;
		logic mod_busy;
		logic cell_empty;
		logic cell_hit;
		logic scan_more;
		logic out_busy;
	} cvq_status_t;

endpackage

// ----- rtl/cvq_ram.sv -----
// single-port-write, single-port-read ram with registered read data
module cvq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cvq_ctrl.sv -----
// sequencer for clearing, writes and read scans of the verdict queue
module cvq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  cvq_pkg::cvq_status_t st,
	output cvq_pkg::cvq_cmd_t    cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_MODW  = 4'd3;
	localparam logic [3:0] S_MODR  = 4'd4;
	localparam logic [3:0] S_WPREV = 4'd5;
	localparam logic [3:0] S_WCUR  = 4'd6;
	localparam logic [3:0] S_WDEC  = 4'd7;
	localparam logic [3:0] S_FIRST = 4'd8;
	localparam logic [3:0] S_SCAN  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       first_empty;

	assign s_axis_tready = (state_q == S_IDLE);
	assign first_empty   = (state_q == S_FIRST) && st.cell_empty;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!st.q_ok) begin
					// unknown queue: echo the position, touch nothing
					if (!st.out_busy) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = cvq_pkg::OUT_ECHO;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = S_MODW;
				end
			end
			S_MODW: begin
				if (!st.mod_busy) begin
					cmd.w_load = 1'b1;
					if (st.op_read) begin
						cmd.mod_start    = 1'b1;
						cmd.mod_sel_rpos = 1'b1;
						state_d          = S_MODR;
					end else begin
						state_d = S_WPREV;
					end
				end
			end
			S_WPREV: begin
				cmd.rd     = 1'b1;
				cmd.ra_sel = cvq_pkg::RA_PREV;
				state_d    = S_WCUR;
			end
			S_WCUR: begin
				cmd.cap_prev = 1'b1;
				cmd.rd       = 1'b1;
				cmd.ra_sel   = cvq_pkg::RA_W;
				state_d      = S_WDEC;
			end
			S_WDEC: begin
				if (!st.out_busy) begin
					cmd.cell_wr  = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_kind = cvq_pkg::OUT_ECHO;
					state_d      = S_IDLE;
				end
			end
			S_MODR: begin
				if (!st.mod_busy) begin
					cmd.r_load = 1'b1;
					cmd.rd     = 1'b1;
					cmd.ra_sel = cvq_pkg::RA_MOD;
					state_d    = S_FIRST;
				end
			end
			S_FIRST, S_SCAN: begin
				if (first_empty || st.cell_hit || !st.scan_more) begin
					if (!st.out_busy) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = (st.cell_hit && !first_empty) ?
							cvq_pkg::OUT_FOUND : cvq_pkg::OUT_MISS;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.scan_adv = 1'b1;
					cmd.rd       = 1'b1;
					cmd.ra_sel   = cvq_pkg::RA_RNEXT;
					state_d      = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/cvq_dp.sv -----
// datapath: item registers, pointers, length reduction, cell access and result register
`include "compacting_verdict_queue_core_assert.svh"

module cvq_dp #(
	parameter int NUM_QUEUES  = cvq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = cvq_pkg::QUEUE_DEPTH_DEF,
	parameter int CELLS       = NUM_QUEUES * QUEUE_DEPTH,
	parameter int AW          = $clog2(CELLS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cvq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            cfg_valid,
	input  logic [cvq_pkg::LEN_CFG_W-1:0]   cfg_data,
	input  cvq_pkg::cvq_cmd_t               cmd,
	output cvq_pkg::cvq_status_t            st,
	output logic                            ram_we,
	output logic [AW-1:0]                   ram_waddr,
	output logic [cvq_pkg::VERDICT_W-1:0]   ram_wdata,
	output logic                            ram_re,
	output logic [AW-1:0]                   ram_raddr,
	input  logic [cvq_pkg::VERDICT_W-1:0]   ram_rdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [cvq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic [0:0]                      m_axis_tuser
);

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int LW      = $clog2(QUEUE_DEPTH + 1);
	localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int MW      = (cvq_pkg::POS_W > PTR_W) ? cvq_pkg::POS_W : PTR_W;
	localparam int CW      = $clog2(MW + 1);
	localparam int XW      = (MW > LW) ? MW : LW;
	localparam int LEN_RST = (QUEUE_DEPTH < 64) ? QUEUE_DEPTH : 64;
	localparam int VW      = cvq_pkg::VERDICT_W;
	localparam int TW      = cvq_pkg::TIME_W;
	localparam int PW      = cvq_pkg::POS_W;
	localparam logic [VW-1:0] EMPTY = '1;

	// configured queue length, already clamped to 1..QUEUE_DEPTH
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    cfg_len;

	// current item
	logic             op_q;
	logic             qok_q;
	logic [QW-1:0]    q_q;
	logic [VW-1:0]    verdict_q;
	logic [PW-1:0]    rpos_q;
	logic [TW-1:0]    wanted_q;

	// pointers
	logic [PTR_W-1:0] wp_q [NUM_QUEUES];
	logic [PTR_W-1:0] w_q;
	logic [PTR_W-1:0] r_q;
	logic [LW-1:0]    steps_q;
	logic [VW-1:0]    cp_q;
	logic [AW-1:0]    clr_q;

	// remainder unit
	logic             mbusy_q;
	logic [CW-1:0]    mcnt_q;
	logic [MW-1:0]    mx_q;
	logic [LW-1:0]    mrem_q;
	logic [MW-1:0]    mx_sel;
	logic             m_short;
	logic [LW:0]      m_t;
	logic [LW:0]      m_sub;
	logic [PTR_W-1:0] mod_rem;

	// pointer arithmetic
	logic [PTR_W-1:0] w_prev;
	logic [LW-1:0]    r_inc;
	logic [PTR_W-1:0] r_next;
	logic             compact;
	logic [PTR_W-1:0] tw;
	logic [LW-1:0]    tw_inc;
	logic [PTR_W-1:0] wp_next;
	logic [PTR_W-1:0] ridx;

	// result register
	logic             out_valid_q;
	logic             found_q;
	logic [VW-1:0]    rv_q;
	logic [PW-1:0]    nrp_q;
	logic             qok_in;

	function automatic logic [AW-1:0] cell_addr(input logic [QW-1:0] q,
		input logic [PTR_W-1:0] idx);
		return AW'(q) * AW'(QUEUE_DEPTH) + AW'(idx);
	endfunction

	// length register
	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LW'(1);
		end else if (32'(cfg_data) > 32'(QUEUE_DEPTH)) begin
			cfg_len = LW'(QUEUE_DEPTH);
		end else begin
			cfg_len = LW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(LEN_RST);
		end else if (cfg_valid) begin
			len_q <= cfg_len;
		end
	end

	// item capture
	assign qok_in = 32'(s_axis_tdata[cvq_pkg::QIDX_LSB +: cvq_pkg::QIDX_W]) < 32'(NUM_QUEUES);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= s_axis_tuser[0];
			qok_q     <= qok_in;
			q_q       <= QW'(s_axis_tdata[cvq_pkg::QIDX_LSB +: cvq_pkg::QIDX_W]);
			verdict_q <= s_axis_tdata[cvq_pkg::WV_LSB +: VW];
			rpos_q    <= s_axis_tdata[cvq_pkg::RP_LSB +: PW];
			wanted_q  <= s_axis_tdata[cvq_pkg::WT_LSB +: TW];
		end
	end

	// remainder by the queue length, one quotient bit a cycle
	assign mx_sel  = cmd.mod_sel_rpos ? MW'(rpos_q) : MW'(wp_q[q_q]);
	assign m_short = XW'(mx_sel) < XW'(len_q);
	assign m_t     = {mrem_q, mx_q[MW-1]};
	assign m_sub   = (m_t >= {1'b0, len_q}) ? (m_t - {1'b0, len_q}) : m_t;
	assign mod_rem = PTR_W'(mrem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.mod_start) begin
			mbusy_q <= !m_short;
			mcnt_q  <= CW'(MW);
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q - CW'(1);
			if (mcnt_q == CW'(1)) begin
				mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			mx_q   <= mx_sel;
			mrem_q <= m_short ? LW'(mx_sel) : '0;
		end else if (mbusy_q) begin
			mx_q   <= mx_q << 1;
			mrem_q <= LW'(m_sub);
		end
	end

	// pointer arithmetic
	assign w_prev  = (w_q == '0) ? PTR_W'(len_q - LW'(1)) : (w_q - PTR_W'(1));
	assign r_inc   = LW'(r_q) + LW'(1);
	assign r_next  = (r_inc == len_q) ? '0 : PTR_W'(r_inc);
	assign compact = (cp_q[TW] == verdict_q[TW]) && (cp_q != ram_rdata) &&
		(ram_rdata != EMPTY);
	assign tw      = compact ? w_prev : w_q;
	assign tw_inc  = LW'(tw) + LW'(1);
	assign wp_next = (tw_inc == len_q) ? '0 : PTR_W'(tw_inc);

	always_ff @(posedge clk) begin
		if (cmd.w_load) begin
			w_q <= mod_rem;
		end
		if (cmd.r_load) begin
			r_q     <= mod_rem;
			steps_q <= '0;
		end else if (cmd.scan_adv) begin
			r_q     <= r_next;
			steps_q <= steps_q + LW'(1);
		end
		if (cmd.cap_prev) begin
			cp_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '{default: '0};
		end else if (cmd.cell_wr) begin
			wp_q[q_q] <= wp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// cell store access
	always_comb begin
		case (cmd.ra_sel)
			cvq_pkg::RA_MOD:   ridx = mod_rem;
			cvq_pkg::RA_PREV:  ridx = w_prev;
			cvq_pkg::RA_W:     ridx = w_q;
			cvq_pkg::RA_RNEXT: ridx = r_next;
			default:           ridx = w_q;
		endcase
	end

	assign ram_re    = cmd.rd;
	assign ram_raddr = cell_addr(q_q, ridx);
	assign ram_we    = cmd.clr_wr || cmd.cell_wr;
	assign ram_waddr = cmd.clr_wr ? clr_q : cell_addr(q_q, tw);
	assign ram_wdata = cmd.clr_wr ? EMPTY : verdict_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				cvq_pkg::OUT_FOUND: begin
					found_q <= 1'b1;
					rv_q    <= ram_rdata;
					nrp_q   <= PW'(r_q);
				end
				cvq_pkg::OUT_MISS: begin
					found_q <= 1'b0;
					rv_q    <= '0;
					nrp_q   <= PW'(r_q);
				end
				default: begin
					found_q <= 1'b0;
					rv_q    <= '0;
					nrp_q   <= rpos_q;
				end
			endcase
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tuser[0] = found_q;
	always_comb begin
		m_axis_tdata                           = '0;
		m_axis_tdata[cvq_pkg::RV_LSB +: VW]    = rv_q;
		m_axis_tdata[cvq_pkg::NRP_LSB +: PW]   = nrp_q;
	end

	// status
	assign st.clr_last   = (clr_q == AW'(CELLS - 1));
	assign st.q_ok       = qok_q;
	assign st.op_read    = (op_q == cvq_pkg::OP_READ);
	assign st.mod_busy   = mbusy_q;
	assign st.cell_empty = (ram_rdata == EMPTY);
	assign st.cell_hit   = (ram_rdata[TW-1:0] >= wanted_q);
	assign st.scan_more  = (r_next != w_q) && ((steps_q + LW'(1)) < len_q);
	assign st.out_busy   = out_valid_q && !m_axis_tready;

	`CVQ_ASSERT_SAME(a_out_free, cmd.out_load, !out_valid_q || m_axis_tready, "result register overwritten before it was taken")
	`CVQ_ASSERT_SAME(a_mod_range, $fell(mbusy_q), mrem_q < len_q, "remainder not below queue length")
	`CVQ_ASSERT_NEXT(a_wp_range, cmd.cell_wr, wp_q[q_q] < len_q, "write pointer left the queue")
	`CVQ_ASSERT_SAME(a_wr_queue, cmd.cell_wr, qok_q && !cmd.clr_wr, "cell write for an unknown queue or during clearing")

endmodule

// ----- rtl/compacting_verdict_queue_core.sv -----
// top level of the compacting verdict queue bank
// A bank of NUM_QUEUES circular queues of verdicts (truth bit on top, timestamp below,
// all-ones word = empty cell), all sharing the queue length set through the cfg channel
// (clamped to 1..QUEUE_DEPTH; after reset 64, or QUEUE_DEPTH if smaller). Items come
// in on the s_axis side, one result per item leaves on the m_axis side in order.
// After reset the block clears its cell store, one cell a cycle, and takes no
// transaction until that pass is done; cfg writes are taken at any time. One item is
// worked at a time through a single cell memory with one read port: a write does two
// cell reads, then the write with possible compaction onto the previous cell; a read
// scans forward from the read position, at most queue length cells. Each stored or
// caller pointer that is not already below the queue length first passes through the
// bit-serial remainder unit. The result register lets the next item be accepted while
// a result still waits on m_axis_tready.
module compacting_verdict_queue_core #(
	parameter int NUM_QUEUES  = cvq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = cvq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// queue_index [3:0], write_verdict [35:4], read_position [41:36],
	// wanted_time [72:42], zero fill [79:73]
	input  logic [cvq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// operation [0]: 0 write verdict, 1 read verdict
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// read_verdict [31:0], next_read_position [37:32], zero fill [39:38]
	output logic [cvq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// found [0]
	output logic [0:0]                      m_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// queue_length write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvq_pkg::LEN_CFG_W-1:0]   cfg_data
);

	localparam int CELLS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = $clog2(CELLS);

	cvq_pkg::cvq_cmd_t    cmd;
	cvq_pkg::cvq_status_t st;

	// cell store port signals
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [cvq_pkg::VERDICT_W-1:0] ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [cvq_pkg::VERDICT_W-1:0] ram_rdata;

	// the length register is always free to take a transaction
	assign cfg_ready = 1'b1;

	// sequencer: clearing pass, write read-modify-write, read scan
	cvq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	// pointers, remainder unit, compaction test, scan compare, result register
	cvq_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CELLS       (CELLS),
		.AW          (AW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// verdict cells of all queues, queue q at q*QUEUE_DEPTH upwards
	cvq_ram #(
		.WIDTH (cvq_pkg::VERDICT_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- verif/cvq_result_checker.sv -----
// result checker for the verdict queue bank: shadow store, prediction and per-field compare
module cvq_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cvq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [cvq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic [0:0]                      m_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cvq_pkg::LEN_CFG_W-1:0]   cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              compactions
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NQ    = cvq_pkg::NUM_QUEUES_DEF;
	localparam int DEPTH = cvq_pkg::QUEUE_DEPTH_DEF;
	localparam logic [cvq_pkg::VERDICT_W-1:0] EMPTY_CELL = '1;

	typedef struct packed {
		logic                          found;
		logic [cvq_pkg::VERDICT_W-1:0] verdict;
		logic [cvq_pkg::POS_W-1:0]     next_pos;
	} verdict_result_t;

	logic [cvq_pkg::VERDICT_W-1:0] cell_store [NQ][DEPTH];
	logic [cvq_pkg::POS_W-1:0]     head_ptr [NQ];
	logic [cvq_pkg::LEN_CFG_W-1:0] length_reg;
	verdict_result_t               awaited_verdicts [$];

	function automatic int unsigned active_length();
		if (length_reg == 0)
			return 1;
		if (length_reg > DEPTH)
			return DEPTH;
		return 32'(length_reg);
	endfunction

	// one item against the shadow store, returns the result it must produce
	function automatic verdict_result_t work_item(input logic op,
			input logic [cvq_pkg::QIDX_W-1:0] q,
			input logic [cvq_pkg::VERDICT_W-1:0] wv,
			input logic [cvq_pkg::POS_W-1:0] rp,
			input logic [cvq_pkg::TIME_W-1:0] wt);
		verdict_result_t res;
		int unsigned     len, w, prev, r, steps;
		res.found    = 1'b0;
		res.verdict  = '0;
		res.next_pos = rp;
		len = active_length();
		w = head_ptr[q] % len;
		if (op == cvq_pkg::OP_WRITE) begin
			prev = (w == 0) ? len - 1 : w - 1;
			// same truth as the previous cell, previous differs from current, current in use
			if (cell_store[q][prev][cvq_pkg::TIME_W] == wv[cvq_pkg::TIME_W] &&
					cell_store[q][prev] != cell_store[q][w] &&
					cell_store[q][w] != EMPTY_CELL) begin
				w = prev;
				compactions++;
			end
			cell_store[q][w] = wv;
			w = (w + 1) % len;
			head_ptr[q] = w[cvq_pkg::POS_W-1:0];
			return res;
		end
		r = rp % len;
		res.next_pos = r[cvq_pkg::POS_W-1:0];
		if (cell_store[q][r] == EMPTY_CELL)
			return res;
		steps = 0;
		do begin
			if (cell_store[q][r][cvq_pkg::TIME_W-1:0] >= wt) begin
				res.found    = 1'b1;
				res.verdict  = cell_store[q][r];
				res.next_pos = r[cvq_pkg::POS_W-1:0];
				return res;
			end
			r = (r + 1) % len;
			steps++;
		end while (r != w && steps < len);
		// ran into the write pointer or visited len cells: step back one slot
		r = (r == 0) ? len - 1 : r - 1;
		res.next_pos = r[cvq_pkg::POS_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_result_t exp_res;
		if (!arst_n) begin
			for (int qi = 0; qi < NQ; qi++) begin
				head_ptr[qi] = '0;
				for (int ci = 0; ci < DEPTH; ci++)
					cell_store[qi][ci] = EMPTY_CELL;
			end
			length_reg = 7'd64;
			awaited_verdicts.delete();
			fail_count  = 0;
			pending     = 0;
			compactions = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				length_reg = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_verdicts.size() == 0) begin
					$error("result transaction with no expected verdict waiting");
					fail_count++;
				end else begin
					exp_res = awaited_verdicts.pop_front();
					if (m_axis_tuser[0] !== exp_res.found) begin
						$error("found: expected %0d, got %0d", exp_res.found, m_axis_tuser[0]);
						fail_count++;
					end
					if (m_axis_tdata[cvq_pkg::RV_LSB +: cvq_pkg::VERDICT_W] !== exp_res.verdict) begin
						$error("read_verdict: expected %h, got %h", exp_res.verdict,
							m_axis_tdata[cvq_pkg::RV_LSB +: cvq_pkg::VERDICT_W]);
						fail_count++;
					end
					if (m_axis_tdata[cvq_pkg::NRP_LSB +: cvq_pkg::POS_W] !== exp_res.next_pos) begin
						$error("next_read_position: expected %0d, got %0d", exp_res.next_pos,
							m_axis_tdata[cvq_pkg::NRP_LSB +: cvq_pkg::POS_W]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_verdicts.push_back(work_item(s_axis_tuser[0],
					s_axis_tdata[cvq_pkg::QIDX_LSB +: cvq_pkg::QIDX_W],
					s_axis_tdata[cvq_pkg::WV_LSB +: cvq_pkg::VERDICT_W],
					s_axis_tdata[cvq_pkg::RP_LSB +: cvq_pkg::POS_W],
					s_axis_tdata[cvq_pkg::WT_LSB +: cvq_pkg::TIME_W]));
			pending = awaited_verdicts.size();
		end
	end

endmodule

// ----- verif/tb_compacting_verdict_queue_core.sv -----
// testbench top for the compacting verdict queue bank: stimulus, stalls, watchdog and verdict
module tb_compacting_verdict_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	// a clearing pass follows reset; the limit is set well above it and above the worst item
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 183;

	typedef logic [cvq_pkg::QIDX_W-1:0]    qidx_t;
	typedef logic [cvq_pkg::VERDICT_W-1:0] verdict_t;
	typedef logic [cvq_pkg::POS_W-1:0]     pos_t;
	typedef logic [cvq_pkg::TIME_W-1:0]    wtime_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic [cvq_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [0:0]                      s_axis_tuser = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [cvq_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic [0:0]                      m_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cvq_pkg::LEN_CFG_W-1:0]   cfg_data = '0;

	int          fail_count, pending, compactions;
	int          idle_cycles = 0;
	int          writes_sent = 0, reads_sent = 0, settings_done = 0;
	int unsigned len_now = 64;
	bit          calm = 1'b0;
	// per-queue stimulus time line and truth, used to build plausible verdict streams
	int unsigned stamp [cvq_pkg::NUM_QUEUES_DEF];
	logic        last_truth [cvq_pkg::NUM_QUEUES_DEF];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	compacting_verdict_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	cvq_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.compactions   (compactions)
	);

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_compacting_verdict_queue_core: errors");
				$finish;
			end
		end
	end

	// receiver: ready low in random bursts, steady once calm
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 8) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// one input transaction; entered and left at a falling edge, tvalid left high
	task automatic push_item(input logic op, input logic [cvq_pkg::QIDX_W-1:0] q,
			input logic [cvq_pkg::VERDICT_W-1:0] wv, input logic [cvq_pkg::POS_W-1:0] rp,
			input logic [cvq_pkg::TIME_W-1:0] wt);
		logic [cvq_pkg::IN_DATA_W-1:0] word;
		word = '0;
		word[cvq_pkg::QIDX_LSB +: cvq_pkg::QIDX_W]  = q;
		word[cvq_pkg::WV_LSB +: cvq_pkg::VERDICT_W] = wv;
		word[cvq_pkg::RP_LSB +: cvq_pkg::POS_W]     = rp;
		word[cvq_pkg::WT_LSB +: cvq_pkg::TIME_W]    = wt;
		// sender gap before the item
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tdata  <= word;
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (op == cvq_pkg::OP_WRITE)
			writes_sent++;
		else
			reads_sent++;
	endtask

	// stop sending and wait until every expected result has been taken, plus a margin
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// queue_length write, called with the block idle but for the first, during the clearing pass
	task automatic set_length(input logic [cvq_pkg::LEN_CFG_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		len_now = (value == 0) ? 1 : ((value > 64) ? 64 : value);
		settings_done++;
	endtask

	// one queue length setting followed by a stretch of random items
	task automatic random_phase(input logic [cvq_pkg::LEN_CFG_W-1:0] len_cfg,
			input int count);
		logic                          op;
		logic [cvq_pkg::QIDX_W-1:0]    q;
		logic [cvq_pkg::VERDICT_W-1:0] wv;
		logic [cvq_pkg::POS_W-1:0]     rp;
		logic [cvq_pkg::TIME_W-1:0]    wt;
		int unsigned                   back;
		settle();
		set_length(len_cfg);
		for (int n = 0; n < count; n++) begin
			// hold off now and then until the result side has drained
			if (!calm && n % 50 == 49 && $urandom_range(0, 2) == 0)
				settle();
			op = 1'($urandom_range(0, 1));
			q  = qidx_t'($urandom);
			wv = verdict_t'($urandom);
			rp = pos_t'($urandom);
			wt = wtime_t'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				// well-formed traffic: rising timestamps per queue, truth mostly repeated
				if ($urandom_range(0, 1))
					q = qidx_t'($urandom_range(0, 3));
				op = ($urandom_range(0, 9) < 6) ? cvq_pkg::OP_WRITE : cvq_pkg::OP_READ;
				if (op == cvq_pkg::OP_WRITE) begin
					stamp[q] += $urandom_range(1, 20);
					if ($urandom_range(0, 9) < 3)
						last_truth[q] = ~last_truth[q];
					wv = {last_truth[q], stamp[q][cvq_pkg::TIME_W-1:0]};
				end else begin
					rp = pos_t'($urandom_range(0, len_now - 1));
					back = $urandom_range(0, 40);
					if ($urandom_range(0, 7) == 0)
						wt = wtime_t'(stamp[q] + $urandom_range(1, 50));
					else
						wt = wtime_t'((stamp[q] > back) ? stamp[q] - back : 0);
				end
			end else if ($urandom_range(0, 15) == 0) begin
				// noise that stores the empty marker
				wv = '1;
			end
			push_item(op, q, wv, rp, wt);
		end
	endtask

	initial begin
		for (int i = 0; i < cvq_pkg::NUM_QUEUES_DEF; i++) begin
			stamp[i]      = $urandom_range(0, 1000);
			last_truth[i] = 1'($urandom_range(0, 1));
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// config is taken during the clearing pass; 127 is clamped to the full depth
		set_length(7'd127);

		// directed: empty cell, extremes of verdict and time, found and not-found scans
		push_item(cvq_pkg::OP_READ,  4'd0,  32'h0000_0000, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd0,  32'h0000_0005, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd0,  32'h8000_000A, 6'd63, 31'h7FFF_FFFF);
		push_item(cvq_pkg::OP_WRITE, 4'd0,  32'h7FFF_FFFF, 6'd21, 31'd0);
		push_item(cvq_pkg::OP_READ,  4'd0,  32'hFFFF_FFFF, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_READ,  4'd0,  32'h0000_0000, 6'd0,  31'd8);
		push_item(cvq_pkg::OP_READ,  4'd0,  32'h0000_0000, 6'd0,  31'h7FFF_FFFF);
		push_item(cvq_pkg::OP_WRITE, 4'd1,  32'h0000_0003, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_READ,  4'd1,  32'h0000_0000, 6'd0,  31'd100);
		push_item(cvq_pkg::OP_READ,  4'd0,  32'h0000_0000, 6'd63, 31'd0);
		// storing the all-ones word leaves the cell looking empty
		push_item(cvq_pkg::OP_WRITE, 4'd15, 32'hFFFF_FFFF, 6'd42, 31'd0);
		push_item(cvq_pkg::OP_READ,  4'd15, 32'h0000_0000, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd15, 32'h8000_0000, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_READ,  4'd15, 32'h0000_0000, 6'd1,  31'd0);

		// directed at length two: wrap, compaction, pointers beyond the length
		settle();
		set_length(7'd2);
		push_item(cvq_pkg::OP_WRITE, 4'd2,  32'h8000_0001, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd2,  32'h8000_0002, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd2,  32'h8000_0003, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_WRITE, 4'd2,  32'h0000_0004, 6'd0,  31'd0);
		push_item(cvq_pkg::OP_READ,  4'd2,  32'h0000_0000, 6'd5,  31'd0);
		push_item(cvq_pkg::OP_READ,  4'd2,  32'h0000_0000, 6'd0,  31'd1000);
		push_item(cvq_pkg::OP_WRITE, 4'd0,  32'h8000_0010, 6'd63, 31'd0);
		push_item(cvq_pkg::OP_READ,  4'd0,  32'h0000_0000, 6'd63, 31'd0);

		// random phases over several lengths, zero and above-depth among them
		random_phase(7'd1,  PHASE_ITEMS);
		random_phase(7'd0,  PHASE_ITEMS);
		random_phase(7'd3,  PHASE_ITEMS);
		random_phase(7'd8,  PHASE_ITEMS);
		random_phase(7'd65, PHASE_ITEMS);
		random_phase(7'd2,  PHASE_ITEMS);
		random_phase(7'd16, PHASE_ITEMS);
		random_phase(7'd5,  PHASE_ITEMS);
		// last stretch runs with no stalls on either side
		calm = 1'b1;
		random_phase(7'd64, PHASE_ITEMS);

		settle();
		repeat (100) @(negedge clk);
		$display("covered %0d writes and %0d reads over %0d queue length settings",
			writes_sent, reads_sent, settings_done);
		$display("the predicted traffic held %0d compacting writes", compactions);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_compacting_verdict_queue_core: clean");
		end else begin
			$display("tb_compacting_verdict_queue_core: errors");
		end
		$finish;
	end

endmodule

// ----- compacting_verdict_queue_core.f -----
+incdir+rtl
rtl/cvq_pkg.sv
rtl/cvq_ram.sv
rtl/cvq_ctrl.sv
rtl/cvq_dp.sv
rtl/compacting_verdict_queue_core.sv
verif/cvq_result_checker.sv
verif/tb_compacting_verdict_queue_core.sv
